// ===== hw/rtl/sbt_pkg.sv =====
// shared constants and codes for the stepped box tile distance block
// no dependencies; compile first
package sbt_pkg;

  localparam int COORD_W       = 32;
  localparam int DE_W          = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int FRAC_BITS_DEF = 16;

  // mode_flags bit positions
  localparam int MF_WRAP  = 0;
  localparam int MF_BOX   = 1;
  localparam int MF_CHEB  = 2;
  localparam int MF_KEEP  = 3;
  localparam int MF_DE    = 4;
  localparam int MF_DELEN = 5;
  localparam int MF_COLOR = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_FLAGS    = 3'd0,
    REG_AXIS_SCALE    = 3'd1,
    REG_ROW_SHIFT     = 3'd2,
    REG_BOX_HALF_SIZE = 3'd3,
    REG_BOX_SHRINK    = 3'd4,
    REG_DE_GAIN       = 3'd5,
    REG_DE_BIAS       = 3'd6,
    REG_COLOR_WEIGHTS = 3'd7
  } cfg_reg_e;

endpackage

// ===== hw/rtl/sbt_if.sv =====
// channel interfaces: point words in, result words out, register writes
// depends on sbt_pkg
interface sbt_point_if import sbt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  logic signed [COORD_W-1:0] pw;
  logic signed [COORD_W-1:0] dist_in;
  logic        [DE_W-1:0]    de_in;
  logic signed [COORD_W-1:0] color_in;
  modport source(output valid, px, py, pz, pw, dist_in, de_in, color_in, input ready);
  modport sink(input valid, px, py, pz, pw, dist_in, de_in, color_in, output ready);
endinterface

interface sbt_result_if import sbt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic signed [COORD_W-1:0] qz;
  logic signed [COORD_W-1:0] qw;
  logic signed [COORD_W-1:0] dist_out;
  logic signed [COORD_W-1:0] de_out;
  logic signed [COORD_W-1:0] color_out;
  modport source(output valid, qx, qy, qz, qw, dist_out, de_out, color_out, input ready);
  modport sink(input valid, qx, qy, qz, qw, dist_out, de_out, color_out, output ready);
endinterface

interface sbt_cfg_if import sbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/stepped_box_tile_distance.sv =====
// top level of the stepped box tile distance transform
// depends on sbt_pkg and the channel interfaces in sbt_if.sv
// one pipeline of 73 register stages followed by a one-word skid buffer
//
// takes one point word per clock while the pipeline is not frozen and returns
// one result word per point, in order; the pipeline depth is set by the
// 32-step integer square root (one result bit per stage, run side by side for
// the box norm and the point length) followed by the 33-step restoring divider
// for the box distance quotient; a stall on the output fills the skid word and
// then freezes the whole pipeline, and it starts again the cycle after the skid
// word is taken; register writes are always accepted and must only happen while
// no point is in flight
module stepped_box_tile_distance import sbt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sbt_point_if.sink  point,
  sbt_result_if.source result,
  sbt_cfg_if.sink    cfg
);

  // fixed point helpers
  localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
  localparam int          UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int          DN_SH = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam logic [62:0] UNIT3 = 63'h0400_0020_0001_0000;  // 1.0 in each packed field

  // stage map
  localparam int ROOT_STEPS  = 32;
  localparam int QUOT_BITS   = 33;
  localparam int ST_SCALE    = 0;                       // axis products, length squares
  localparam int ST_ROW      = 1;                       // floor shift, odd row test
  localparam int ST_SHIFT    = 2;                       // row shift on x, mark c
  localparam int ST_BOX      = 3;                       // wrap, clamp against half size
  localparam int ST_SQR      = 4;                       // squares, chebyshev, color sum
  localparam int ST_SUM      = 5;                       // sum of squares
  localparam int ST_ROOT     = 6;                       // square roots, one bit per stage
  localparam int ST_PREP     = ST_ROOT + ROOT_STEPS;    // box numerator, divisor, de*len
  localparam int ST_DIV      = ST_PREP + 1;             // divider, one bit per stage
  localparam int ST_FIN      = ST_DIV + QUOT_BITS;      // quotient sign, min merge, select
  localparam int NST         = ST_FIN + 1;
  localparam int LAST        = NST - 1;
  // derivative update rides along the first divider stages
  localparam int ST_DE_PART  = ST_DIV;
  localparam int ST_DE_ADD   = ST_DIV + 1;
  localparam int ST_DE_SHIFT = ST_DIV + 2;
  localparam int ST_DE_BIAS  = ST_DIV + 3;

  localparam logic [95:0] PROD_CAP = 96'd1 << 40;

  typedef struct packed {
    logic [3:0][31:0]   p;        // input point x,y,z,w
    logic signed [31:0] dmin;
    logic [30:0]        de;
    logic signed [31:0] color;
    logic [2:0][63:0]   prod;
    logic [3:0][63:0]   lsq;
    logic [2:0][31:0]   z;
    logic               ca;
    logic               cb;
    logic               cc;
    logic [2:0][31:0]   a;
    logic [2:0][63:0]   asq;
    logic [31:0]        cheb;
    logic [63:0]        bn;       // box root remainder and result
    logic [63:0]        br;
    logic [63:0]        ln;       // length root remainder and result
    logic [63:0]        lr;
    logic               lcarry;
    logic               neg;
    logic [31:0]        rem;
    logic [32:0]        low;
    logic [32:0]        q;
    logic [31:0]        den;
    logic [63:0]        dea;
    logic [63:0]        pl;
    logic [63:0]        ph;
    logic [95:0]        pp;
    logic signed [41:0] dev;
    logic [31:0]        de_res;
  } item_t;

  // configuration registers
  logic [6:0]         mode_flags;
  logic [62:0]        axis_scale;
  logic signed [31:0] row_shift;
  logic [62:0]        box_half_size;
  logic signed [31:0] box_shrink;
  logic signed [31:0] de_gain;
  logic signed [31:0] de_bias;
  logic [62:0]        color_weights;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags    <= 7'd18;
      axis_scale    <= UNIT3;
      row_shift     <= 32'(ONE >> 1);
      box_half_size <= UNIT3;
      box_shrink    <= '0;
      de_gain       <= 32'(ONE);
      de_bias       <= '0;
      color_weights <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_MODE_FLAGS:    mode_flags    <= cfg.data[6:0];
        REG_AXIS_SCALE:    axis_scale    <= cfg.data[62:0];
        REG_ROW_SHIFT:     row_shift     <= cfg.data[31:0];
        REG_BOX_HALF_SIZE: box_half_size <= cfg.data[62:0];
        REG_BOX_SHRINK:    box_shrink    <= cfg.data[31:0];
        REG_DE_GAIN:       de_gain       <= cfg.data[31:0];
        REG_DE_BIAS:       de_bias       <= cfg.data[31:0];
        REG_COLOR_WEIGHTS: color_weights <= cfg.data[62:0];
      endcase
    end
  end

  // packed q5.16 field brought to the working fraction width
  function automatic logic signed [31:0] unpack_q(logic [62:0] r, int k);
    logic signed [20:0] f;
    logic signed [31:0] e;
    f = r[21*k +: 21];
    e = 32'(f);
    e = (e <<< UP_SH) >>> DN_SH;
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // one step of the bitwise square root, returns {remainder, root}
  function automatic logic [127:0] root_step(logic [63:0] n, logic [63:0] r, int j);
    logic [63:0] b;
    logic [63:0] t;
    b = 64'd1 << (62 - 2 * j);
    t = r + b;
    if (n >= t) return {n - t, (r >> 1) + b};
    return {n, r >> 1};
  endfunction

  logic signed [31:0] scale [3];
  logic signed [31:0] half [3];
  logic signed [31:0] cw [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scale[i] = unpack_q(axis_scale, i);
      half[i]  = unpack_q(box_half_size, i);
      cw[i]    = unpack_q(color_weights, i);
    end
  end

  // pipeline
  item_t pipe [NST];
  item_t nxt  [NST];
  item_t src  [NST];
  logic  vld  [NST];
  logic  vsrc [NST];
  item_t entry;
  item_t skid;
  logic  skid_full;
  logic  adv;

  assign adv         = !skid_full;
  assign point.ready = adv;

  always_comb begin
    entry          = '0;
    entry.p[0]     = point.px;
    entry.p[1]     = point.py;
    entry.p[2]     = point.pz;
    entry.p[3]     = point.pw;
    entry.dmin     = point.dist_in;
    entry.de       = point.de_in;
    entry.color    = point.color_in;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int K = k;

    if (K == 0) begin : g_head
      assign src[K]  = entry;
      assign vsrc[K] = point.valid;
    end else begin : g_link
      assign src[K]  = pipe[K-1];
      assign vsrc[K] = vld[K-1];
    end

    always_comb begin
      item_t              x;
      item_t              n;
      logic [31:0]        m;
      logic signed [33:0] zs;
      logic signed [33:0] ms;
      logic signed [33:0] df;
      logic signed [34:0] csum;
      logic [64:0]        lsum;
      logic [127:0]       rs;
      logic [31:0]        norm;
      logic signed [33:0] d;
      logic signed [33:0] md;
      logic [65:0]        nfull;
      logic [32:0]        len;
      logic [32:0]        r2;
      logic [31:0]        gabs;
      logic [95:0]        sft;
      logic               sticky;
      logic signed [34:0] qs;
      logic signed [31:0] qsat;
      x      = src[K];
      n      = x;
      m      = '0;
      zs     = '0;
      ms     = '0;
      df     = '0;
      csum   = '0;
      lsum   = '0;
      rs     = '0;
      norm   = '0;
      d      = '0;
      md     = '0;
      nfull  = '0;
      len    = '0;
      r2     = '0;
      gabs   = '0;
      sft    = '0;
      sticky = 1'b0;
      qs     = '0;
      qsat   = '0;

      if (K == ST_SCALE) begin
        for (int i = 0; i < 3; i++) begin
          n.prod[i] = 64'($signed(x.p[i])) * 64'(scale[i]);
        end
        for (int i = 0; i < 4; i++) begin
          m        = x.p[i][31] ? (~x.p[i] + 32'd1) : x.p[i];
          n.lsq[i] = 64'(m) * 64'(m);
        end
      end else if (K == ST_ROW) begin
        for (int i = 0; i < 3; i++) begin
          n.z[i] = sat32(66'($signed(x.prod[i]) >>> FRAC_BITS));
        end
        // odd row when y mod 2 is above one
        n.ca   = n.z[1][FRAC_BITS] & (|n.z[1][FRAC_BITS-1:0]);
        n.cb   = !n.ca;
        lsum   = 65'(x.lsq[0]) + 65'(x.lsq[1]) + 65'(x.lsq[2]) + 65'(x.lsq[3]);
        n.ln   = lsum[63:0];
        n.lcarry = lsum[64];
        n.lr   = '0;
      end else if (K == ST_SHIFT) begin
        if (x.ca) begin
          n.z[0] = sat32(66'($signed(x.z[0])) + 66'(row_shift));
        end
        n.cc = n.z[0][FRAC_BITS] & (|n.z[0][FRAC_BITS-1:0]);
      end else if (K == ST_BOX) begin
        if (mode_flags[MF_WRAP]) begin
          n.z[0] = 32'(x.z[0][FRAC_BITS-1:0]);
          n.z[1] = 32'(x.z[1][FRAC_BITS-1:0]);
        end
        for (int i = 0; i < 3; i++) begin
          zs     = 34'($signed(n.z[i]));
          ms     = zs[33] ? -zs : zs;
          df     = ms - 34'(half[i]);
          n.a[i] = df[33] ? 32'd0 : df[31:0];
        end
      end else if (K == ST_SQR) begin
        for (int i = 0; i < 3; i++) begin
          n.asq[i] = 64'(x.a[i]) * 64'(x.a[i]);
        end
        n.cheb = (x.a[0] > x.a[1]) ? x.a[0] : x.a[1];
        if (x.a[2] > n.cheb) n.cheb = x.a[2];
        if (mode_flags[MF_BOX]) begin
          for (int i = 0; i < 3; i++) begin
            n.z[i] = x.a[i][31] ? 32'h7fff_ffff : x.a[i];
          end
        end
        if (mode_flags[MF_COLOR]) begin
          csum = 35'(x.color);
          if (x.ca) csum = csum + 35'(cw[0]);
          if (x.cb) csum = csum + 35'(cw[1]);
          if (x.cc) csum = csum + 35'(cw[2]);
          n.color = sat32(66'(csum));
        end
      end else if (K == ST_SUM) begin
        // wraps at 64 bits
        n.bn = x.asq[0] + x.asq[1] + x.asq[2];
        n.br = '0;
      end else if (K >= ST_ROOT && K < ST_PREP) begin
        rs   = root_step(x.bn, x.br, K - ST_ROOT);
        n.bn = rs[127:64];
        n.br = rs[63:0];
        rs   = root_step(x.ln, x.lr, K - ST_ROOT);
        n.ln = rs[127:64];
        n.lr = rs[63:0];
      end else if (K == ST_PREP) begin
        norm   = mode_flags[MF_CHEB] ? x.cheb : x.br[31:0];
        d      = $signed({2'b00, norm}) - 34'(box_shrink);
        n.neg  = d[33];
        md     = d[33] ? -d : d;
        // magnitude times one, top part seeds the remainder
        nfull  = 66'(md[32:0]) << FRAC_BITS;
        n.rem  = nfull[64:33];
        n.low  = nfull[32:0];
        n.q    = '0;
        n.den  = 32'({1'b0, x.de}) + ONE[31:0];
        len    = x.lcarry ? 33'h1_0000_0000 : x.lr[32:0];
        n.dea  = mode_flags[MF_DELEN] ? (64'(x.de) * 64'(len)) : 64'(x.de);
      end else if (K >= ST_DIV && K < ST_FIN) begin
        r2    = {x.rem, x.low[32]};
        n.low = x.low << 1;
        if (r2 >= {1'b0, x.den}) begin
          n.rem = 32'(r2 - {1'b0, x.den});
          n.q   = {x.q[31:0], 1'b1};
        end else begin
          n.rem = r2[31:0];
          n.q   = {x.q[31:0], 1'b0};
        end
      end else if (K == ST_FIN) begin
        qs   = $signed({2'b00, x.q});
        if (x.neg) qs = -qs - 35'(x.rem != '0);
        qsat = sat32(66'(qs));
        if (mode_flags[MF_BOX] && (qsat < x.dmin)) n.dmin = qsat;
        if (mode_flags[MF_KEEP]) begin
          for (int i = 0; i < 3; i++) n.z[i] = x.p[i];
        end
      end

      // derivative update, overlapped with the divider
      if (K == ST_DE_PART) begin
        gabs = de_gain[31] ? (~de_gain + 32'd1) : de_gain;
        n.pl = 64'(x.dea[31:0]) * 64'(gabs);
        n.ph = 64'(x.dea[63:32]) * 64'(gabs);
      end
      if (K == ST_DE_ADD) begin
        n.pp = 96'(x.pl) + (96'(x.ph) << 32);
      end
      if (K == ST_DE_SHIFT) begin
        if (mode_flags[MF_DELEN]) begin
          sft    = x.pp >> (2 * FRAC_BITS);
          sticky = |(x.pp & ((96'd1 << (2 * FRAC_BITS)) - 96'd1));
        end else begin
          sft    = x.pp >> FRAC_BITS;
          sticky = |(x.pp & ((96'd1 << FRAC_BITS) - 96'd1));
        end
        if (sft > PROD_CAP) begin
          sft    = PROD_CAP;
          sticky = 1'b0;
        end
        n.dev = $signed({1'b0, sft[40:0]});
        if (de_gain[31]) n.dev = -n.dev - 42'(sticky);
      end
      if (K == ST_DE_BIAS) begin
        n.de_res = mode_flags[MF_DE] ? sat32(66'(x.dev) + 66'(de_bias)) : 32'(x.de);
      end

      nxt[K] = n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[K] <= 1'b0;
      end else if (adv) begin
        vld[K] <= vsrc[K];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[K] <= nxt[K];
      end
    end
  end

  // skid word catches the last stage when the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full && vld[LAST] && !result.ready) begin
      skid_full <= 1'b1;
    end else if (skid_full && result.ready) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid <= pipe[LAST];
    end
  end

  item_t ow;
  assign ow = skid_full ? skid : pipe[LAST];

  assign result.valid     = skid_full | vld[LAST];
  assign result.qx        = ow.z[0];
  assign result.qy        = ow.z[1];
  assign result.qz        = ow.z[2];
  assign result.qw        = ow.p[3];
  assign result.dist_out  = ow.dmin;
  assign result.de_out    = ow.de_res;
  assign result.color_out = ow.color;

  // a stalled word in the last stage must land in the skid buffer
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && !skid_full && !result.ready) |=> skid_full)
    else $error("stalled word not captured");

  // a held skid word keeps its contents
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !result.ready) |=> (skid_full && $stable(skid)))
    else $error("skid word changed while stalled");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |-> (pipe[LAST].rem < pipe[LAST].den))
    else $error("divider remainder out of range");

endmodule
